### sv/mmm_pkg.sv
// Shared types, widths, register indexes and stage numbers of the motor mixer.
// No dependencies; every other file of the mixer imports it.
package mmm_pkg;

   localparam int THR_W     = 10;
   localparam int TORQUE_W  = 16;
   localparam int MAXT_W    = 15;
   localparam int GAIN_W    = 16;
   localparam int MINP_W    = 12;
   localparam int COUNT_W   = 3;
   localparam int COEF_W    = 16;
   localparam int MIX_W     = 3 * COEF_W;
   localparam int DELTA_W   = 11;
   localparam int LEVEL_W   = 10;
   localparam int PULSE_W   = 13;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 48;

   localparam int MAX_MOTORS_DEF = 4;
   localparam int MIX_SLOTS      = 4;

   localparam int DELTA_LIMIT  = 720;
   localparam int CUT_THROTTLE = 15;
   localparam int LEVEL_MAX    = 1000;
   localparam int SERVO_CENTER = 1450;
   localparam int FOUR_MOTORS  = 4;

   localparam logic [MAXT_W-1:0]  MAXT_RESET  = 15'd256;
   localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd12800;
   localparam logic [MINP_W-1:0]  MINP_RESET  = 12'd1000;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd3;
   localparam logic [MIX_W-1:0] MIX_RESET [MIX_SLOTS] = '{
      48'h0000_1000_F000, 48'h0000_1000_1000, 48'h0000_E333_0000, 48'h0
   };

   // pipeline stage numbers
   localparam int STG_CLAMP  = 0;
   localparam int STG_MULT   = 1;
   localparam int STG_DELTA  = 2;
   localparam int STG_PROD   = 3;
   localparam int STG_LEVEL  = 4;
   localparam int STG_OUT    = 5;
   localparam int NUM_STAGES = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MAX_TORQUE  = 4'd0,
      REG_TORQUE_GAIN = 4'd1,
      REG_MIN_PULSE   = 4'd2,
      REG_MOTOR_COUNT = 4'd3,
      REG_MIX0        = 4'd4,
      REG_MIX1        = 4'd5,
      REG_MIX2        = 4'd6,
      REG_MIX3        = 4'd7
   } csr_reg_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
   } pipe_ctrl_type;

   typedef struct packed {
      logic [THR_W-1:0]           throttle_level;
      logic signed [TORQUE_W-1:0] roll_torque;
      logic signed [TORQUE_W-1:0] pitch_torque;
      logic signed [TORQUE_W-1:0] yaw_torque;
   } req_type;

   typedef struct packed {
      logic [PULSE_W-1:0] pulse_out0;
      logic [PULSE_W-1:0] pulse_out1;
      logic [PULSE_W-1:0] pulse_out2;
      logic [PULSE_W-1:0] pulse_out3;
      logic               motors_cut;
   } rsp_type;

endpackage

### sv/mmm_torque.sv
// Torque to delta path of one axis: clamp, gain multiply, truncate and clamp.
// Three register stages driven by the pipeline enables; uses mmm_pkg.
module mmm_torque (
   input  logic                                clock,
   input  mmm_pkg::pipe_ctrl_type              ctrl,
   input  logic signed [mmm_pkg::TORQUE_W-1:0] torque,
   input  logic [mmm_pkg::MAXT_W-1:0]          max_torque,
   input  logic [mmm_pkg::GAIN_W-1:0]          torque_gain,
   output logic signed [mmm_pkg::DELTA_W-1:0]  delta
);
   import mmm_pkg::*;

   localparam int WIDE_W = TORQUE_W + 1;
   localparam int PROD_W = TORQUE_W + GAIN_W + 1;
   localparam int SHIFT  = 14;
   localparam logic signed [PROD_W-1:0] BIAS = PROD_W'((1 << SHIFT) - 1);
   localparam logic signed [PROD_W-1:0] LIM  = PROD_W'(DELTA_LIMIT);

   logic signed [WIDE_W-1:0]   raw_x, lim_p, lim_n, sel;
   logic signed [TORQUE_W-1:0] t_ff, t_in;
   logic signed [GAIN_W:0]     gain_s;
   logic signed [PROD_W-1:0]   p_ff, p_in, p_bias, q;
   logic signed [DELTA_W-1:0]  delta_ff, delta_in;

   always_comb begin
      raw_x = WIDE_W'(torque);
      lim_p = $signed({2'b00, max_torque});
      lim_n = -lim_p;
      if (raw_x > lim_p) begin
         sel = lim_p;
      end else if (raw_x < lim_n) begin
         sel = lim_n;
      end else begin
         sel = raw_x;
      end
      t_in = sel[TORQUE_W-1:0];
   end

   assign gain_s = $signed({1'b0, torque_gain});
   assign p_in   = PROD_W'(t_ff) * PROD_W'(gain_s);

   // truncate toward zero, then clamp to the delta limit
   always_comb begin
      p_bias = p_ff + (p_ff[PROD_W-1] ? BIAS : '0);
      q      = p_bias >>> SHIFT;
      if (q > LIM) begin
         delta_in = DELTA_W'(DELTA_LIMIT);
      end else if (q < -LIM) begin
         delta_in = -DELTA_W'(DELTA_LIMIT);
      end else begin
         delta_in = q[DELTA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[STG_CLAMP]) begin
         t_ff <= t_in;
      end
      if (ctrl.en[STG_MULT]) begin
         p_ff <= p_in;
      end
      if (ctrl.en[STG_DELTA]) begin
         delta_ff <= delta_in;
      end
   end

   assign delta = delta_ff;

endmodule

### sv/mmm_mix.sv
// Level of one motor: three coefficient products, then sum with throttle, truncate and clamp; cut forces zero.
// Two register stages driven by the pipeline enables; uses mmm_pkg.
module mmm_mix (
   input  logic                               clock,
   input  mmm_pkg::pipe_ctrl_type             ctrl,
   input  logic [mmm_pkg::MIX_W-1:0]          mix,
   input  logic signed [mmm_pkg::DELTA_W-1:0] delta_roll,
   input  logic signed [mmm_pkg::DELTA_W-1:0] delta_pitch,
   input  logic signed [mmm_pkg::DELTA_W-1:0] delta_yaw,
   input  logic [mmm_pkg::THR_W-1:0]          throttle,
   input  logic                               cut,
   output logic [mmm_pkg::LEVEL_W-1:0]        level
);
   import mmm_pkg::*;

   localparam int PROD_W = COEF_W + DELTA_W;
   localparam int FRAC   = 12;
   localparam int ACC_W  = PROD_W + 2;
   localparam logic signed [ACC_W-1:0] BIAS = ACC_W'((1 << FRAC) - 1);
   localparam logic signed [ACC_W-1:0] LMAX = ACC_W'(LEVEL_MAX);

   logic signed [COEF_W-1:0]  coef [3];
   logic signed [DELTA_W-1:0] dlt  [3];
   logic signed [PROD_W-1:0]  prod_ff [3];
   logic signed [PROD_W-1:0]  prod_in [3];
   logic signed [ACC_W-1:0]   acc, acc_bias, q;
   logic [LEVEL_W-1:0]        level_ff, level_in;

   assign dlt[0] = delta_roll;
   assign dlt[1] = delta_pitch;
   assign dlt[2] = delta_yaw;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         coef[k]    = $signed(mix[k*COEF_W +: COEF_W]);
         prod_in[k] = PROD_W'(coef[k]) * PROD_W'(dlt[k]);
      end
   end

   always_comb begin
      acc = $signed({{(ACC_W - THR_W - FRAC){1'b0}}, throttle, {FRAC{1'b0}}})
            + ACC_W'(prod_ff[0]) + ACC_W'(prod_ff[1]) + ACC_W'(prod_ff[2]);
      acc_bias = acc + (acc[ACC_W-1] ? BIAS : '0);
      q        = acc_bias >>> FRAC;
      if (cut || q[ACC_W-1]) begin
         level_in = '0;
      end else if (q > LMAX) begin
         level_in = LEVEL_W'(LEVEL_MAX);
      end else begin
         level_in = q[LEVEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[STG_PROD]) begin
         prod_ff <= prod_in;
      end
      if (ctrl.en[STG_LEVEL]) begin
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

endmodule

### sv/multirotor_motor_mixer.sv
// Top level of the multirotor motor mixer: registers, pipeline control, output stage.
// Instantiates mmm_torque and mmm_mix; uses mmm_pkg.
//
//   channel | direction | handshake             | beat
//   req     | in        | req_valid/req_ready   | req_type: throttle and three torques
//   rsp     | out       | rsp_valid/rsp_ready   | rsp_type: four pulses and cut flag
//   csr     | in        | csr_valid/csr_ready   | csr_index, csr_wdata (always ready)
//
// Six register stages: clamp, gain multiply, delta, mix products, level, pulse.
// One beat per cycle in and out, unless a low rsp_ready stalls the output stage.
// Each stage moves when it is empty or the next stage moves, so bubbles collapse
// and a stalled rsp still lets upstream stages fill.
// Reset clears the valid bits and loads the register defaults.
module multirotor_motor_mixer #(
   parameter int MAX_MOTORS = mmm_pkg::MAX_MOTORS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  mmm_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output mmm_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mmm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mmm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mmm_pkg::*;

   localparam bit HAS_FOURTH = (MAX_MOTORS >= FOUR_MOTORS);

   logic [MAXT_W-1:0]  max_torque_ff;
   logic [GAIN_W-1:0]  torque_gain_ff;
   logic [MINP_W-1:0]  min_pulse_ff;
   logic [COUNT_W-1:0] motor_count_ff;
   logic [MIX_W-1:0]   mix_ff [MAX_MOTORS];

   logic [NUM_STAGES-1:0] v_ff, en;
   pipe_ctrl_type         ctrl;

   logic [THR_W-1:0]          thr_ff [STG_LEVEL];
   logic                      cut_ff [STG_OUT];
   logic signed [DELTA_W-1:0] yaw_ff [STG_OUT-STG_PROD];
   logic                      cut_in;

   logic signed [DELTA_W-1:0] d_roll, d_pitch, d_yaw;
   logic [LEVEL_W-1:0]        level [MAX_MOTORS];
   logic [LEVEL_W-1:0]        lvl3;
   logic                      four_mode;
   rsp_type                   rsp_ff, rsp_in;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_torque_ff  <= MAXT_RESET;
         torque_gain_ff <= GAIN_RESET;
         min_pulse_ff   <= MINP_RESET;
         motor_count_ff <= COUNT_RESET;
         for (int m = 0; m < MAX_MOTORS; m++) begin
            mix_ff[m] <= MIX_RESET[m];
         end
      end else if (csr_valid) begin
         case (csr_index)
            REG_MAX_TORQUE:  max_torque_ff  <= csr_wdata[MAXT_W-1:0];
            REG_TORQUE_GAIN: torque_gain_ff <= csr_wdata[GAIN_W-1:0];
            REG_MIN_PULSE:   min_pulse_ff   <= csr_wdata[MINP_W-1:0];
            REG_MOTOR_COUNT: motor_count_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
         for (int m = 0; m < MAX_MOTORS; m++) begin
            if (csr_index == CSR_IDX_W'(int'(REG_MIX0) + m)) begin
               mix_ff[m] <= csr_wdata[MIX_W-1:0];
            end
         end
      end
   end

   // pipeline control
   always_comb begin
      en[NUM_STAGES-1] = !v_ff[NUM_STAGES-1] || rsp_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign ctrl.en   = en;
   assign req_ready = en[STG_CLAMP];
   assign rsp_valid = v_ff[STG_OUT];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // sideband carried beside the datapath
   assign cut_in = (req_data.throttle_level <= THR_W'(CUT_THROTTLE));

   always_ff @(posedge clock) begin
      if (en[0]) begin
         thr_ff[0] <= req_data.throttle_level;
         cut_ff[0] <= cut_in;
      end
      for (int k = 1; k < STG_LEVEL; k++) begin
         if (en[k]) begin
            thr_ff[k] <= thr_ff[k-1];
         end
      end
      for (int k = 1; k < STG_OUT; k++) begin
         if (en[k]) begin
            cut_ff[k] <= cut_ff[k-1];
         end
      end
      if (en[STG_PROD]) begin
         yaw_ff[0] <= d_yaw;
      end
      if (en[STG_LEVEL]) begin
         yaw_ff[1] <= yaw_ff[0];
      end
   end

   mmm_torque u_roll (
      .clock       (clock),
      .ctrl        (ctrl),
      .torque      (req_data.roll_torque),
      .max_torque  (max_torque_ff),
      .torque_gain (torque_gain_ff),
      .delta       (d_roll)
   );

   mmm_torque u_pitch (
      .clock       (clock),
      .ctrl        (ctrl),
      .torque      (req_data.pitch_torque),
      .max_torque  (max_torque_ff),
      .torque_gain (torque_gain_ff),
      .delta       (d_pitch)
   );

   mmm_torque u_yaw (
      .clock       (clock),
      .ctrl        (ctrl),
      .torque      (req_data.yaw_torque),
      .max_torque  (max_torque_ff),
      .torque_gain (torque_gain_ff),
      .delta       (d_yaw)
   );

   for (genvar m = 0; m < MAX_MOTORS; m++) begin : g_motor
      mmm_mix u_mix (
         .clock       (clock),
         .ctrl        (ctrl),
         .mix         (mix_ff[m]),
         .delta_roll  (d_roll),
         .delta_pitch (d_pitch),
         .delta_yaw   (d_yaw),
         .throttle    (thr_ff[STG_PROD]),
         .cut         (cut_ff[STG_PROD]),
         .level       (level[m])
      );
   end

   if (HAS_FOURTH) begin : g_fourth
      assign lvl3 = level[FOUR_MOTORS-1];
   end else begin : g_servo_only
      assign lvl3 = '0;
   end

   assign four_mode = HAS_FOURTH && (motor_count_ff == COUNT_W'(FOUR_MOTORS));

   // output stage
   always_comb begin
      rsp_in.pulse_out0 = PULSE_W'(min_pulse_ff) + PULSE_W'(level[0]);
      rsp_in.pulse_out1 = PULSE_W'(min_pulse_ff) + PULSE_W'(level[1]);
      rsp_in.pulse_out2 = PULSE_W'(min_pulse_ff) + PULSE_W'(level[2]);
      if (four_mode) begin
         rsp_in.pulse_out3 = PULSE_W'(min_pulse_ff) + PULSE_W'(lvl3);
      end else begin
         rsp_in.pulse_out3 = PULSE_W'(SERVO_CENTER) + PULSE_W'(yaw_ff[1]);
      end
      rsp_in.motors_cut = cut_ff[STG_LEVEL];
   end

   always_ff @(posedge clock) begin
      if (en[STG_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   // checks
   a_cut_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.motors_cut |->
         rsp_data.pulse_out0 == PULSE_W'(min_pulse_ff) &&
         rsp_data.pulse_out1 == PULSE_W'(min_pulse_ff) &&
         rsp_data.pulse_out2 == PULSE_W'(min_pulse_ff))
      else $error("cut beat carries a nonzero motor level");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_data.pulse_out0 >= PULSE_W'(min_pulse_ff) &&
         rsp_data.pulse_out0 <= PULSE_W'(min_pulse_ff) + PULSE_W'(LEVEL_MAX))
      else $error("motor 0 pulse outside level range");

   a_servo_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !four_mode |->
         rsp_data.pulse_out3 >= PULSE_W'(SERVO_CENTER - DELTA_LIMIT) &&
         rsp_data.pulse_out3 <= PULSE_W'(SERVO_CENTER + DELTA_LIMIT))
      else $error("servo pulse outside delta range");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with an empty output stage");

   a_accept_flow: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v_ff[STG_CLAMP])
      else $error("accepted beat lost at first stage");

endmodule
